// File: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, off while reset is asserted
`define AWMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// concurrent assertion that also holds during reset
`define AWMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/awmd_pkg.sv
package awmd_pkg;

  localparam int unsigned WINDOW_DEF = 16;

  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned SQ_W       = 2 * AXIS_W;
  localparam int unsigned REM_W      = MAG_W + 2;
  localparam int unsigned SQRT_STEPS = MAG_W;
  localparam int unsigned ITER_W     = $clog2(SQRT_STEPS);
  localparam int unsigned ONE_G_W    = 15;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ONE_G_W-1:0] ONE_G_RST    = 15'd16384;
  localparam logic [THR_W-1:0]   STD_THR_RST  = 16'd819;
  localparam logic [THR_W-1:0]   MEAN_TOL_RST = 16'd1638;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_G    = 2'd0,
    CFG_STD_THR  = 2'd1,
    CFG_MEAN_TOL = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT,
    ST_SQR_MAG,
    ST_UPDATE,
    ST_MUL_A,
    ST_MUL_B,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_Z,
    OP_SQRT_FIRST,
    OP_SQRT,
    OP_SQR_MAG,
    OP_UPDATE,
    OP_MUL_A,
    OP_MUL_B
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
    logic   commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_restart;
  } dp_status_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic [TIME_W-1:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic              moved;
    logic [TIME_W-1:0] last_move_ms;
    logic [MAG_W-1:0]  magnitude;
  } out_item_t;

endpackage

// File: rtl/awmd_ctrl.sv
module awmd_ctrl import awmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e              state_q, state_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    cmd_o       = '{load: 1'b0, op: OP_NONE, commit: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = status_i.is_restart ? ST_FINISH : ST_SQ_X;
      end
      ST_SQ_X: begin
        cmd_o.op = OP_SQ_X;
        state_d  = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd_o.op = OP_SQ_Y;
        state_d  = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        cmd_o.op = OP_SQ_Z;
        iter_d   = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = (iter_q == '0) ? OP_SQRT_FIRST : OP_SQRT;
        iter_d   = iter_q + 1'b1;
        if (iter_q == ITER_W'(SQRT_STEPS - 1)) begin
          state_d = ST_SQR_MAG;
        end
      end
      ST_SQR_MAG: begin
        cmd_o.op = OP_SQR_MAG;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd_o.op = OP_MUL_A;
        state_d  = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.op = OP_MUL_B;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/awmd_dp.sv
module awmd_dp import awmd_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_item_t              in_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output out_item_t             out_data_o
);

  localparam int unsigned N_W    = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = MAG_W + N_W;
  localparam int unsigned SQS_W  = 2 * MAG_W + N_W;
  localparam int unsigned SPR_W  = 2 * MAG_W + 2 * N_W;
  localparam int unsigned NTHR_W = THR_W + N_W;
  localparam int unsigned TGT_W  = ONE_G_W + N_W;
  localparam int unsigned NTOL_W = THR_W + N_W;

  // configuration
  logic [ONE_G_W-1:0] one_g_q;
  logic [THR_W-1:0]   thr_q;
  logic [THR_W-1:0]   tol_q;

  // window state
  logic [N_W-1:0]    fill_q, fill_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SQS_W-1:0]  sumsq_q, sumsq_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic [MAG_W-1:0]  window_q [WINDOW];

  // working registers
  in_item_t          in_q;
  logic [SQ_W-1:0]   sq_q;
  logic [SQ_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [MAG_W-1:0]  root_q;
  logic [MAG_W-1:0]  old_q;
  logic [SQ_W-1:0]   magsq_q;
  logic [SQ_W-1:0]   oldsq_q;
  logic [SPR_W-1:0]  nsq_q;
  logic [SPR_W-1:0]  ss_q;
  logic [NTHR_W-1:0] nthr_q;
  logic [TGT_W-1:0]  tgt_q;
  logic [NTOL_W-1:0] ntol_q;
  logic [SPR_W-1:0]  thr2_q;
  logic [SPR_W-1:0]  spread_q;
  logic [SUM_W-1:0]  off_q;
  out_item_t         out_q;

  logic signed [AXIS_W-1:0] axis_sel;
  logic signed [SQ_W-1:0]   axis_sq;

  logic              sqrt_first;
  logic [REM_W-1:0]  rem_in, rem_sh, trial;
  logic [MAG_W-1:0]  root_in;
  logic [SQ_W-1:0]   rad_in;
  logic              take;

  logic              full;
  logic              moved;
  logic [SUM_W-1:0]  tgt_ext;

  assign status_o.is_restart = in_q.cmd;

  // one axis squared per cycle
  always_comb begin
    case (cmd_i.op)
      OP_SQ_X: axis_sel = in_q.axis_x;
      OP_SQ_Y: axis_sel = in_q.axis_y;
      default: axis_sel = in_q.axis_z;
    endcase
  end
  assign axis_sq = SQ_W'(axis_sel) * SQ_W'(axis_sel);

  // digit-by-digit square root, two radicand bits per step
  assign sqrt_first = (cmd_i.op == OP_SQRT_FIRST);
  assign rem_in     = sqrt_first ? '0 : rem_q;
  assign root_in    = sqrt_first ? '0 : root_q;
  assign rad_in     = sqrt_first ? sq_q : rad_q;
  assign rem_sh     = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
  assign trial      = {root_in, 2'b01};
  assign take       = (rem_sh >= trial);

  assign full    = (fill_q == N_W'(WINDOW));
  assign tgt_ext = SUM_W'(tgt_q);
  assign moved   = (spread_q > thr2_q) || (off_q > ntol_q);

  // window bookkeeping and last movement time
  always_comb begin
    fill_d  = fill_q;
    slot_d  = slot_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    last_d  = last_q;
    if (cmd_i.op == OP_UPDATE) begin
      if (full) begin
        sum_d   = sum_q - SUM_W'(old_q) + SUM_W'(root_q);
        sumsq_d = sumsq_q - SQS_W'(oldsq_q) + SQS_W'(magsq_q);
      end else begin
        fill_d  = fill_q + 1'b1;
        sum_d   = sum_q + SUM_W'(root_q);
        sumsq_d = sumsq_q + SQS_W'(magsq_q);
      end
      slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
    end
    if (cmd_i.commit) begin
      if (in_q.cmd) begin
        fill_d  = '0;
        slot_d  = '0;
        sum_d   = '0;
        sumsq_d = '0;
        last_d  = in_q.now_ms;
      end else if (moved) begin
        last_d = in_q.now_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_g_q <= ONE_G_RST;
      thr_q   <= STD_THR_RST;
      tol_q   <= MEAN_TOL_RST;
      fill_q  <= '0;
      slot_q  <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      last_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      slot_q  <= slot_d;
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ONE_G:    one_g_q <= cfg_data_i[ONE_G_W-1:0];
          CFG_STD_THR:  thr_q   <= cfg_data_i[THR_W-1:0];
          CFG_MEAN_TOL: tol_q   <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // window memory, read of the oldest entry is registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SQ_X) begin
      old_q <= window_q[slot_q];
    end
    if (cmd_i.op == OP_UPDATE) begin
      window_q[slot_q] <= root_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    case (cmd_i.op)
      OP_SQ_X: begin
        sq_q <= unsigned'(axis_sq);
      end
      OP_SQ_Y, OP_SQ_Z: begin
        sq_q <= sq_q + unsigned'(axis_sq);
      end
      OP_SQRT_FIRST, OP_SQRT: begin
        rem_q  <= take ? rem_sh - trial : rem_sh;
        root_q <= {root_in[MAG_W-2:0], take};
        rad_q  <= {rad_in[SQ_W-3:0], 2'b00};
      end
      OP_SQR_MAG: begin
        magsq_q <= SQ_W'(root_q) * SQ_W'(root_q);
        oldsq_q <= SQ_W'(old_q) * SQ_W'(old_q);
      end
      OP_MUL_A: begin
        nsq_q  <= SPR_W'(fill_q) * SPR_W'(sumsq_q);
        ss_q   <= SPR_W'(sum_q) * SPR_W'(sum_q);
        nthr_q <= NTHR_W'(fill_q) * NTHR_W'(thr_q);
        tgt_q  <= TGT_W'(fill_q) * TGT_W'(one_g_q);
        ntol_q <= NTOL_W'(fill_q) * NTOL_W'(tol_q);
      end
      OP_MUL_B: begin
        thr2_q   <= SPR_W'(nthr_q) * SPR_W'(nthr_q);
        spread_q <= nsq_q - ss_q;
        off_q    <= (sum_q >= tgt_ext) ? sum_q - tgt_ext : tgt_ext - sum_q;
      end
      default: ;
    endcase
    if (cmd_i.commit) begin
      if (in_q.cmd) begin
        out_q <= '{moved: 1'b0, last_move_ms: in_q.now_ms, magnitude: '0};
      end else begin
        out_q <= '{moved: moved, last_move_ms: last_d, magnitude: root_q};
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// File: rtl/accel_window_motion_detect.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   in_data_i   (in_item_t)
// out       output     out_valid_o / out_stall_i out_data_o  (out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// a sample passes through decode, the x, y and z squares, the one-bit-per-step square root
// unit, the squared magnitudes, the window update and the products before its result is
// committed, and no new transfer is taken until then; a restart goes from decode to commit
// rst_ni is asynchronous, active low; it restores register defaults and empties the window
// a result waits in the output register while out_stall_i is high; the next item
// can still be taken and worked on, and it is held back only at its final step
module accel_window_motion_detect import awmd_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input samples and restart commands
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  // one result per input transfer
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  // register writes, always ready
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes never wait
  assign cfg_ready_o = 1'b1;

  // sequencer: squares, root steps, window update, products, commit
  awmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, window memory, running sums and configuration registers
  awmd_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/awmd_checker.sv
`include "assert_macros.svh"

module awmd_checker import awmd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_data_i
);

  localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

  // a stalled result holds
  `AWMD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i), "stalled result changed")

  // one item at a time: busy right after a transfer
  `AWMD_ASSERT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_i |=> in_stall_i, "input taken while busy")

  // magnitude of three 16-bit axes stays in range
  `AWMD_ASSERT(a_mag_range, clk_i, rst_ni, out_valid_i |-> out_data_i.magnitude <= MAG_MAX, "magnitude out of range")

  // no result during reset, flops may still be unknown at the very first edge
  `AWMD_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> out_valid_i !== 1'b1, "result valid during reset")

endmodule

bind accel_window_motion_detect awmd_checker u_awmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

// File: tb/accel_window_motion_detect_tb.sv
module accel_window_motion_detect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import awmd_pkg::*;

  localparam int unsigned WIN = WINDOW_DEF;
  // the one register index that maps to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  // generous run limit, far beyond the slowest legal run
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  // ---------------------------------------------------------------------------
  // block ports, inputs all known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  accel_window_motion_detect i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // detector mirror: registers, magnitude window, last-motion stamp
  // ---------------------------------------------------------------------------
  logic [ONE_G_W-1:0] cfg_one_g    = ONE_G_RST;
  logic [THR_W-1:0]   cfg_std_thr  = STD_THR_RST;
  logic [THR_W-1:0]   cfg_mean_tol = MEAN_TOL_RST;

  logic [MAG_W-1:0]   win_mag [WIN];
  int unsigned        win_slot   = 0;
  int unsigned        win_fill   = 0;
  longint unsigned    win_sum    = 0;
  longint unsigned    win_sq_sum = 0;
  logic [TIME_W-1:0]  last_move  = '0;

  out_item_t exp_results [$];

  // hard stop in case a handshake never completes
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout after %0d ns, %0d results still pending", RUN_LIMIT_NS,
             exp_results.size());
    $display("[accel_window_motion_detect] ERROR");
    $finish;
  end

  // traffic shaping, percent of cycles spent idle on each side
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // random sample shaping
  logic [TIME_W-1:0] clock_ms   = '0;
  int                motion_amp = 60;

  int unsigned n_errors    = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_restarts  = 0;
  int unsigned n_moved     = 0;
  int unsigned n_cfg_xfers = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // advance the mirror by one transfer and return what the block must answer
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t       res;
    longint signed   x, y, z;
    longint unsigned sq, probe, root, old, n, spread, target, off;
    logic            motion;
    res = '0;
    if (it.cmd) begin
      // restart: empty window, stamp the time, report nothing moved
      win_slot   = 0;
      win_fill   = 0;
      win_sum    = 0;
      win_sq_sum = 0;
      last_move  = it.now_ms;
      res.last_move_ms = it.now_ms;
      n_restarts++;
      return res;
    end
    x  = longint'(it.axis_x);
    y  = longint'(it.axis_y);
    z  = longint'(it.axis_z);
    sq = x * x + y * y + z * z;
    // floor square root, two bits of the radicand per step
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > sq) probe >>= 2;
    while (probe != 0) begin
      if (sq >= root + probe) begin
        sq   = sq - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    // full window: the oldest magnitude drops out of both sums
    if (win_fill >= WIN) begin
      old        = 64'(win_mag[win_slot]);
      win_sum    = win_sum - old;
      win_sq_sum = win_sq_sum - old * old;
    end else begin
      win_fill++;
    end
    win_mag[win_slot] = root[MAG_W-1:0];
    win_sum    = win_sum + root;
    win_sq_sum = win_sq_sum + root * root;
    win_slot   = (win_slot + 1) % WIN;
    n      = 64'(win_fill);
    spread = n * win_sq_sum - win_sum * win_sum;
    target = n * 64'(cfg_one_g);
    off    = (win_sum >= target) ? win_sum - target : target - win_sum;
    motion = (spread > n * n * 64'(cfg_std_thr) * 64'(cfg_std_thr)) ||
             (off > n * 64'(cfg_mean_tol));
    if (motion) begin
      last_move = it.now_ms;
      n_moved++;
    end
    res.moved        = motion;
    res.last_move_ms = last_move;
    res.magnitude    = root[MAG_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall, every result transfer checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (exp_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %p", out_data_o));
      end else begin
        want = exp_results.pop_front();
        if (out_data_o.moved !== want.moved)
          report_mismatch($sformatf("result %0d moved: expected %0b, got %0b",
                                    n_checked, want.moved, out_data_o.moved));
        if (out_data_o.last_move_ms !== want.last_move_ms)
          report_mismatch($sformatf("result %0d last_move_ms: expected 0x%08h, got 0x%08h",
                                    n_checked, want.last_move_ms,
                                    out_data_o.last_move_ms));
        if (out_data_o.magnitude !== want.magnitude)
          report_mismatch($sformatf("result %0d magnitude: expected %0d, got %0d",
                                    n_checked, want.magnitude, out_data_o.magnitude));
        n_checked++;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // sample side
  // ---------------------------------------------------------------------------
  // one input transfer; valid stays high afterwards for back-to-back items,
  // callers that stop sending drop it through the drain task
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    exp_results.push_back(predict_result(it));
    n_sent++;
  endtask

  // stop sending and hold until every pending result has come out
  task automatic wait_results_drained();
    if (in_valid_i !== 1'b0) in_valid_i <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
  endtask

  // one register transfer, mirrored at the edge that takes it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_ONE_G:    cfg_one_g    = data[ONE_G_W-1:0];
      CFG_STD_THR:  cfg_std_thr  = data[THR_W-1:0];
      CFG_MEAN_TOL: cfg_mean_tol = data[THR_W-1:0];
      default: ; // unmapped index, the write is dropped
    endcase
    n_cfg_xfers++;
  endtask

  // all three registers in a row; only legal while nothing is pending
  task automatic set_config(logic [CFG_DATA_W-1:0] one_g, logic [CFG_DATA_W-1:0] thr,
                            logic [CFG_DATA_W-1:0] tol);
    write_reg(CFG_ONE_G, one_g);
    write_reg(CFG_STD_THR, thr);
    write_reg(CFG_MEAN_TOL, tol);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t item_of(logic cmd, int x, int y, int z, logic [31:0] now);
    in_item_t it;
    it.cmd    = cmd;
    it.axis_x = 16'(x);
    it.axis_y = 16'(y);
    it.axis_z = 16'(z);
    it.now_ms = now;
    return it;
  endfunction

  // mostly a sensor near rest (gravity on one axis plus jitter of varying
  // strength), some full-range noise and a few restarts
  function automatic in_item_t make_sample();
    in_item_t    it;
    int unsigned pick;
    int          z;
    pick = $urandom_range(99);
    if ($urandom_range(24) == 0) begin
      case ($urandom_range(3))
        0: motion_amp = 0;
        1: motion_amp = 60;
        2: motion_amp = 500;
        default: motion_amp = 4000;
      endcase
    end
    // time mostly creeps forward, now and then it jumps anywhere
    if ($urandom_range(49) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(1, 25);
    it = item_of(1'b0, $urandom(), $urandom(), $urandom(), clock_ms);
    if (pick < 5) begin
      it.cmd = 1'b1;
    end else if (pick < 85) begin
      z = int'(cfg_one_g) + $urandom_range(0, 2 * motion_amp) - motion_amp;
      if (z > 32767) z = 32767;
      if ($urandom_range(7) == 0) z = -z;
      it.axis_x = 16'($urandom_range(0, 2 * motion_amp) - motion_amp);
      it.axis_y = 16'($urandom_range(0, 2 * motion_amp) - motion_amp);
      it.axis_z = 16'(z);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset register values, axis extremes, zero magnitude, restart, time wrap
  task automatic test_directed_extremes();
    send_item(item_of(1'b0, 0, 0, 16384, 32'd10));          // exactly one g, at rest
    send_item(item_of(1'b0, 0, 0, 0, 32'd20));              // free fall, zero magnitude
    send_item(item_of(1'b0, 32767, 32767, 32767, 32'd30));
    send_item(item_of(1'b0, -32768, -32768, -32768, 32'd40)); // largest magnitude
    send_item(item_of(1'b0, -32768, 32767, 0, 32'd50));
    send_item(item_of(1'b0, 1, -1, 1, 32'hFFFF_FFFF));
    send_item(item_of(1'b1, -1, 21845, -21846, 32'hFFFF_FFFF)); // restart, junk axes
    send_item(item_of(1'b0, 0, 0, -16384, 32'd0));
    send_item(item_of(1'b0, 16384, 0, 0, 32'd1));
    send_item(item_of(1'b0, 0, -16384, 1, 32'h8000_0000));
    wait_results_drained();
  endtask

  // zero and all-ones register settings, out-of-range data bits and the
  // unmapped index
  task automatic test_register_limits();
    // one_g written with only bit 15 set keeps zero, both limits zero
    set_config(16'h8000, 16'h0000, 16'h0000);
    send_item(item_of(1'b1, 0, 0, 0, 32'd100));
    send_item(item_of(1'b0, 0, 0, 0, 32'd101));
    send_item(item_of(1'b0, 0, 0, 5, 32'd102));
    send_item(item_of(1'b0, 0, 0, 5, 32'd103));
    wait_results_drained();
    // all-ones data: one_g keeps its low 15 bits
    write_reg(CFG_ONE_G, 16'hFFFF);
    write_reg(CFG_STD_THR, 16'hFFFF);
    write_reg(CFG_MEAN_TOL, 16'hFFFF);
    // unmapped index must leave every register alone
    write_reg(CFG_IDX_UNUSED, 16'h0000);
    cfg_valid_i <= 1'b0;
    send_item(item_of(1'b1, 0, 0, 0, 32'd200));
    send_item(item_of(1'b0, 32767, 32767, 32767, 32'd201));
    send_item(item_of(1'b0, 0, 0, 0, 32'd202));
    send_item(item_of(1'b0, -32768, -32768, -32768, 32'd203));
    wait_results_drained();
  endtask

  // random traffic under one idling pattern, in two halves with a full drain
  // and a fresh register setting between them
  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned count);
    logic [CFG_DATA_W-1:0] one_g, thr, tol;
    for (int half = 0; half < 2; half++) begin
      wait_results_drained();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      case ($urandom_range(3))
        0: one_g = CFG_DATA_W'(ONE_G_RST);
        1: one_g = 16'd4096;
        2: one_g = 16'd8192;
        default: one_g = CFG_DATA_W'($urandom_range(1, 32767));
      endcase
      thr = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2500));
      tol = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3000));
      if (send_pct == 17 && half == 0) begin
        one_g = CFG_DATA_W'(ONE_G_RST);
        thr   = STD_THR_RST;
        tol   = MEAN_TOL_RST;
      end
      set_config(one_g, thr, tol);
      repeat ((count + half) / 2) send_item(make_sample());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_register_limits();
    test_random_traffic(17, 73, 317);
    test_random_traffic(73, 17, 317);
    test_random_traffic(0, 0, 317);
    wait_results_drained();
    // after the drain, give the block time to misbehave
    repeat (60) @(posedge clk_i);
    if (exp_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", exp_results.size()));
    $display("covered %0d item transfers (%0d restarts), %0d results checked, %0d moved",
             n_sent, n_restarts, n_checked, n_moved);
    $display("register transfers %0d, three idling patterns, %0d mismatches",
             n_cfg_xfers, n_errors);
    if (n_errors == 0) begin
      $display("[accel_window_motion_detect] OK");
    end else begin
      $display("[accel_window_motion_detect] ERROR");
    end
    $finish;
  end

endmodule
